/* rtl/three_channel_programmable_timer_core_defines.svh */
// Assertion macros used by the checker file.
`ifndef THREE_CHANNEL_PROGRAMMABLE_TIMER_CORE_DEFINES_SVH
`define THREE_CHANNEL_PROGRAMMABLE_TIMER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define TPT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tpt check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define TPT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tpt check failed");

`endif

/* rtl/tpt_pkg.sv */
package tpt_pkg;

  localparam int NUM_CH   = 3;
  localparam int MODE_W   = 2;
  localparam int S_DATA_W = 16;
  localparam int M_DATA_W = 16;

  // request kinds, carried on the input tuser
  typedef enum logic [MODE_W-1:0] {
    MODE_WRITE = 2'd0,
    MODE_READ  = 2'd1,
    MODE_TICK  = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  // control register bit positions
  localparam int CTL_RESET  = 0;  // ch0: hold all; ch1: offset 0 selects ch0
  localparam int CTL_SRC    = 1;  // internal clock when set
  localparam int CTL_DUAL   = 2;  // dual-byte counting
  localparam int CTL_NOLOAD = 4;  // latch write leaves count alone
  localparam int CTL_IE     = 6;  // interrupt enable

  // register offsets with a fixed meaning
  localparam logic [2:0] OFF_CTL_A  = 3'd0;
  localparam logic [2:0] OFF_STATUS = 3'd1;

  // output tdata field positions
  localparam int RD_LO    = 0;
  localparam int IRQ_BIT  = 8;
  localparam int FIRED_LO = 9;

  localparam logic [15:0] COUNT_RESET = 16'hffff;

endpackage

/* rtl/three_channel_programmable_timer_core.sv */
// Three-channel programmable timer core behind an eight-register byte-wide
// map. Each request is a bus write, a bus read or a clock tick (tuser:
// 0 write, 1 read, 2 tick, 3 no-op). Input tdata from bit 0 up: offset[2:0],
// data[7:0], internal_tick, external_ticks[2:0], one zero pad bit. Each
// request yields exactly one response; output tdata from bit 0 up:
// read_data[7:0] (zero unless a read), irq (status bit 7 after the
// request), fired[2:0] (channels that underflowed on this request), four
// zero pad bits. Throughput is one request per clock unless output stalls.
// All register updates for a request settle in a single combinational
// pass ahead of the state flops, and the response lands in an output
// register, so s_axis_tready stays high while that register is empty or
// being drained. Reads clear channel flags only after a status read saw
// them set; a latch write clears its channel flag directly.
module three_channel_programmable_timer_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // offset[2:0], data[10:3], internal_tick[11], external_ticks[14:12], pad[15]
  input  logic [tpt_pkg::S_DATA_W-1:0]  s_axis_tdata,
  // mode[1:0]
  input  logic [tpt_pkg::MODE_W-1:0]    s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // read_data[7:0], irq[8], fired[11:9], pad[15:12]
  output logic [tpt_pkg::M_DATA_W-1:0]  m_axis_tdata
);
  import tpt_pkg::*;

  // result of one count-down step
  typedef struct packed {
    logic        expired;
    logic [15:0] cnt;
  } step_t;

  function automatic step_t count_step(input logic dual, input logic [15:0] c,
                                       input logic [15:0] l);
    step_t r;
    r.expired = 1'b0;
    r.cnt     = c - 16'd1;
    if (dual) begin
      if (c[7:0] == 8'd0) begin
        r.cnt[7:0] = l[7:0];
        if (c[15:8] == 8'd0) begin
          r.cnt[15:8] = l[15:8];
          r.expired   = 1'b1;
        end else begin
          r.cnt[15:8] = c[15:8] - 8'd1;
        end
      end else begin
        r.cnt = {c[15:8], c[7:0] - 8'd1};
      end
    end else if (c == 16'd0) begin
      r.cnt     = l;
      r.expired = 1'b1;
    end
    return r;
  endfunction

  // timer state
  logic [7:0]        ctrl       [NUM_CH];
  logic [15:0]       latch      [NUM_CH];
  logic [15:0]       count      [NUM_CH];
  logic [NUM_CH-1:0] flags;       // per-channel interrupt flags
  logic [NUM_CH-1:0] rsi;         // flags seen by a status read
  logic [7:0]        msb_buf;
  logic [7:0]        lsb_buf;

  logic [7:0]        ctrl_next  [NUM_CH];
  logic [15:0]       latch_next [NUM_CH];
  logic [15:0]       count_next [NUM_CH];
  logic [NUM_CH-1:0] flags_next;
  logic [NUM_CH-1:0] rsi_next;
  logic [7:0]        msb_buf_next;
  logic [7:0]        lsb_buf_next;

  // output register
  logic                out_valid;
  logic [M_DATA_W-1:0] out_data;

  // request fields
  mode_t       req_mode;
  logic [2:0]  req_off;
  logic [7:0]  req_data;
  logic        req_itick;
  logic [2:0]  req_eticks;
  logic        accept;

  // response fields
  logic [7:0]        rd;
  logic [NUM_CH-1:0] fired;
  logic              irq_now;
  logic              irq_next;

  assign req_mode   = mode_t'(s_axis_tuser);
  assign req_off    = s_axis_tdata[2:0];
  assign req_data   = s_axis_tdata[10:3];
  assign req_itick  = s_axis_tdata[11];
  assign req_eticks = s_axis_tdata[14:12];

  assign s_axis_tready = !out_valid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // composite interrupt of the current state (status bit 7)
  assign irq_now = |(flags & {ctrl[2][CTL_IE], ctrl[1][CTL_IE], ctrl[0][CTL_IE]});

  always_comb begin
    logic [1:0] sel;
    logic [1:0] ch;
    logic [7:0] diffs;
    logic       pulse;
    step_t      st;
    ctrl_next    = ctrl;
    latch_next   = latch;
    count_next   = count;
    flags_next   = flags;
    rsi_next     = rsi;
    msb_buf_next = msb_buf;
    lsb_buf_next = lsb_buf;
    rd           = 8'd0;
    fired        = '0;
    sel          = 2'd0;
    ch           = 2'd0;
    diffs        = 8'd0;
    pulse        = 1'b0;
    st           = '0;
    case (req_mode)
      MODE_WRITE: begin
        if (req_off[2:1] == 2'd0) begin
          // control write; offset 0 goes to ch0 or ch2 by ch1 bit 0
          if (req_off[0]) begin
            sel = 2'd1;
          end else begin
            sel = ctrl[1][CTL_RESET] ? 2'd0 : 2'd2;
          end
          diffs = req_data ^ ctrl[sel];
          ctrl_next[sel] = req_data;
          if (sel == 2'd0 && diffs[CTL_RESET]) begin
            if (!req_data[CTL_RESET]) begin
              for (int i = 0; i < NUM_CH; i++) begin
                count_next[i] = latch[i];
              end
            end
            flags_next = '0;
          end
          if (diffs[CTL_SRC]) begin
            count_next[sel] = latch[sel];
          end
        end else if (!req_off[0]) begin
          msb_buf_next = req_data;
        end else begin
          ch = req_off[2:1] - 2'd1;
          latch_next[ch] = {msb_buf, req_data};
          flags_next[ch] = 1'b0;
          if (!ctrl[ch][CTL_NOLOAD]) begin
            count_next[ch] = {msb_buf, req_data};
          end
        end
      end
      MODE_READ: begin
        if (req_off == OFF_CTL_A) begin
          rd = 8'd0;
        end else if (req_off == OFF_STATUS) begin
          rd       = {irq_now, 4'd0, flags};
          rsi_next = rsi | flags;
        end else if (!req_off[0]) begin
          ch = req_off[2:1] - 2'd1;
          rd = count[ch][15:8];
          lsb_buf_next = count[ch][7:0];
          if (rsi[ch]) begin
            flags_next[ch] = 1'b0;
          end
        end else begin
          rd = lsb_buf;
        end
      end
      MODE_TICK: begin
        if (!ctrl[0][CTL_RESET]) begin
          for (int i = 0; i < NUM_CH; i++) begin
            pulse = ctrl[i][CTL_SRC] ? req_itick : req_eticks[i];
            if (pulse) begin
              st = count_step(ctrl[i][CTL_DUAL], count[i], latch[i]);
              count_next[i] = st.cnt;
              if (st.expired) begin
                flags_next[i] = 1'b1;
                rsi_next[i]   = 1'b0;
                fired[i]      = 1'b1;
              end
            end
          end
        end
      end
      default: begin
      end
    endcase
    irq_next = |(flags_next & {ctrl_next[2][CTL_IE], ctrl_next[1][CTL_IE],
                               ctrl_next[0][CTL_IE]});
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CH; i++) begin
        ctrl[i]  <= 8'd0;
        latch[i] <= COUNT_RESET;
        count[i] <= COUNT_RESET;
      end
      flags   <= '0;
      rsi     <= '0;
      msb_buf <= 8'd0;
      lsb_buf <= 8'd0;
    end else if (accept) begin
      ctrl    <= ctrl_next;
      latch   <= latch_next;
      count   <= count_next;
      flags   <= flags_next;
      rsi     <= rsi_next;
      msb_buf <= msb_buf_next;
      lsb_buf <= lsb_buf_next;
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= {4'd0, fired, irq_next, rd};
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

endmodule

/* rtl/tpt_checker.sv */
`include "three_channel_programmable_timer_core_defines.svh"

module tpt_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic [tpt_pkg::MODE_W-1:0]    s_axis_tuser,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [tpt_pkg::M_DATA_W-1:0]  m_axis_tdata
);
  import tpt_pkg::*;

  logic acc;
  assign acc = s_axis_tvalid && s_axis_tready;

  // pending response is held until taken
  `TPT_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  // empty output slot never stalls the input
  `TPT_ASSERT_NOW(a_ready_free, !m_axis_tvalid, s_axis_tready)
  // only reads return data
  `TPT_ASSERT_NEXT(a_rd_zero, acc && s_axis_tuser != MODE_READ,
                   m_axis_tdata[RD_LO+7:RD_LO] == 8'd0)
  // only ticks fire channels
  `TPT_ASSERT_NEXT(a_fired_tick, acc && s_axis_tuser != MODE_TICK,
                   m_axis_tdata[FIRED_LO+2:FIRED_LO] == 3'd0)

endmodule

bind three_channel_programmable_timer_core tpt_checker u_tpt_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

/* tb/three_channel_programmable_timer_core_tb.sv */
module three_channel_programmable_timer_core_tb;
  import tpt_pkg::*;

  localparam int STALL_LIMIT    = 2000;  // cycles without any handshake
  localparam int RX_HOLD_CYCLES = 300;   // long sink hold-off
  localparam int RANDOM_REQS    = 1200;
  localparam logic [2:0] OFF_CTL_B = 3'd1;  // write side of offset 1

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  // offset[2:0], data[10:3], internal_tick[11], external_ticks[14:12], pad[15]
  logic [S_DATA_W-1:0] s_axis_tdata = '0;
  // mode[1:0]
  logic [MODE_W-1:0]   s_axis_tuser = MODE_NONE;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // read_data[7:0], irq[8], fired[11:9], pad[15:12]
  logic [M_DATA_W-1:0] m_axis_tdata;

  three_channel_programmable_timer_core u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Timer shadow state, advanced once per accepted request.
  // ---------------------------------------------------------------------
  logic [7:0]  tmr_ctl   [NUM_CH];
  logic [15:0] tmr_latch [NUM_CH];
  logic [15:0] tmr_count [NUM_CH];
  logic [7:0]  tmr_status;     // [2:0] channel flags, [7] composite
  logic [2:0]  tmr_seen;       // flags a status read has shown
  logic [7:0]  tmr_msb_buf;
  logic [7:0]  tmr_lsb_buf;

  // expected responses, {fired, irq, read_data}, oldest first
  logic [11:0] timer_resp_q [$];
  logic [11:0] resp_want;

  int mismatch_count = 0;
  int req_count      = 0;   // requests that do something (no-ops excluded)
  int burst_left     = 1;
  int stall_cycles   = 0;

  // sink hold-off handshake: test bumps the ask, sink process acts once
  int rx_hold_ask  = 0;
  int rx_hold_seen = 0;
  int rx_hold_left = 0;
  int rx_span      = 0;
  int rx_style     = 0;

  initial begin
    for (int i = 0; i < NUM_CH; i++) begin
      tmr_ctl[i]   = 8'h00;
      tmr_latch[i] = COUNT_RESET;
      tmr_count[i] = COUNT_RESET;
    end
    tmr_status  = 8'h00;
    tmr_seen    = 3'b000;
    tmr_msb_buf = 8'h00;
    tmr_lsb_buf = 8'h00;
  end

  // status bit 7 = OR over channels of (flag & interrupt enable)
  function automatic void update_composite();
    logic c;
    c = 1'b0;
    for (int i = 0; i < NUM_CH; i++)
      if (tmr_status[i] && tmr_ctl[i][CTL_IE]) c = 1'b1;
    tmr_status = {c, 4'b0000, tmr_status[2:0]};
  endfunction

  // Applies one request to the shadow state and returns the response.
  function automatic logic [11:0] timer_response(mode_t m, logic [2:0] off, logic [7:0] d,
                                                 logic it, logic [2:0] et);
    int         ch;
    int         sel;
    logic [7:0] diffs;
    logic [7:0] rd;
    logic [2:0] fired;
    logic [15:0] v;
    logic [7:0] lo;
    logic [7:0] hi;
    logic       hit;
    logic       pulse;
    rd    = 8'h00;
    fired = 3'b000;
    case (m)
      MODE_WRITE: begin
        if (off == OFF_CTL_A || off == OFF_CTL_B) begin
          // offset 0 targets ch0 or ch2 depending on ch1 control bit 0
          sel = (off == OFF_CTL_B) ? 1 : (tmr_ctl[1][CTL_RESET] ? 0 : 2);
          diffs = d ^ tmr_ctl[sel];
          tmr_ctl[sel] = d;
          if (sel == 0 && diffs[CTL_RESET]) begin
            if (!d[CTL_RESET])
              for (int i = 0; i < NUM_CH; i++) tmr_count[i] = tmr_latch[i];
            tmr_status = 8'h00;
          end
          if (diffs[CTL_SRC]) tmr_count[sel] = tmr_latch[sel];
        end else if (!off[0]) begin
          tmr_msb_buf = d;
        end else begin
          ch = (int'(off) - 3) / 2;
          tmr_latch[ch]  = {tmr_msb_buf, d};
          tmr_status[ch] = 1'b0;
          if (!tmr_ctl[ch][CTL_NOLOAD]) tmr_count[ch] = tmr_latch[ch];
        end
      end
      MODE_READ: begin
        if (off == OFF_CTL_A) begin
          rd = 8'h00;
        end else if (off == OFF_STATUS) begin
          update_composite();
          tmr_seen = tmr_seen | tmr_status[2:0];
          rd = tmr_status;
        end else if (!off[0]) begin
          ch = (int'(off) - 2) / 2;
          v  = tmr_count[ch];
          if (tmr_seen[ch]) tmr_status[ch] = 1'b0;
          tmr_lsb_buf = v[7:0];
          rd = v[15:8];
        end else begin
          rd = tmr_lsb_buf;
        end
      end
      MODE_TICK: begin
        if (!tmr_ctl[0][CTL_RESET]) begin
          for (ch = 0; ch < NUM_CH; ch++) begin
            pulse = tmr_ctl[ch][CTL_SRC] ? it : et[ch];
            if (pulse) begin
              hit = 1'b0;
              v   = tmr_count[ch];
              if (tmr_ctl[ch][CTL_DUAL]) begin
                lo = v[7:0];
                hi = v[15:8];
                if (lo == 8'h00) begin
                  lo = tmr_latch[ch][7:0];
                  if (hi == 8'h00) begin
                    hi  = tmr_latch[ch][15:8];
                    hit = 1'b1;
                  end else begin
                    hi = hi - 8'd1;
                  end
                end else begin
                  lo = lo - 8'd1;
                end
                tmr_count[ch] = {hi, lo};
              end else if (v == 16'h0000) begin
                tmr_count[ch] = tmr_latch[ch];
                hit = 1'b1;
              end else begin
                tmr_count[ch] = v - 16'd1;
              end
              if (hit) begin
                tmr_status[ch] = 1'b1;
                tmr_seen[ch]   = 1'b0;
                fired[ch]      = 1'b1;
              end
            end
          end
        end
      end
      default: ;
    endcase
    update_composite();
    return {fired, tmr_status[7], rd};
  endfunction

  // ---------------------------------------------------------------------
  // Source side: one request per call, bursts of random length with
  // random gaps. tvalid stays up across a burst.
  // ---------------------------------------------------------------------
  task automatic send_req(mode_t m, logic [2:0] off, logic [7:0] d, logic it, logic [2:0] et);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, et, it, d, off};
    s_axis_tuser  <= m;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    timer_resp_q.push_back(timer_response(m, off, d, it, et));
    if (m != MODE_NONE) req_count++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 40);
      // a quarter of the bursts run back to back
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Source pauses until every expected response is back.
  task automatic drain_responses();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (timer_resp_q.size() != 0) @(posedge clk);
  endtask

  // One random operation; most are well-formed sequences with random
  // content (latch programming, status-then-counter reads), the rest noise.
  task automatic random_op();
    int         r;
    int         ch;
    logic [2:0] off;
    logic [7:0] d;
    r  = $urandom_range(0, 99);
    ch = $urandom_range(0, NUM_CH - 1);
    if (r < 40) begin
      send_req(MODE_TICK, 3'($urandom), 8'($urandom), 1'($urandom), 3'($urandom));
    end else if (r < 55) begin
      // short latches so channels underflow often
      d = ($urandom_range(0, 4) != 0) ? 8'($urandom_range(0, 2)) : 8'($urandom);
      send_req(MODE_WRITE, 3'(2 + 2 * ch), d, 1'($urandom), 3'($urandom));
      d = ($urandom_range(0, 2) != 0) ? 8'($urandom_range(0, 9)) : 8'($urandom);
      send_req(MODE_WRITE, 3'(3 + 2 * ch), d, 1'($urandom), 3'($urandom));
    end else if (r < 65) begin
      off = 3'($urandom_range(0, 1));
      d   = 8'($urandom);
      // keep the global hold mostly released
      if (off == OFF_CTL_A && tmr_ctl[1][CTL_RESET] && $urandom_range(0, 7) != 0)
        d[CTL_RESET] = 1'b0;
      send_req(MODE_WRITE, off, d, 1'($urandom), 3'($urandom));
    end else if (r < 80) begin
      send_req(MODE_READ, OFF_STATUS, 8'($urandom), 1'($urandom), 3'($urandom));
      send_req(MODE_READ, 3'(2 + 2 * ch), 8'($urandom), 1'($urandom), 3'($urandom));
      send_req(MODE_READ, 3'(3 + 2 * ch), 8'($urandom), 1'($urandom), 3'($urandom));
    end else if (r < 95) begin
      send_req(MODE_READ, 3'($urandom), 8'($urandom), 1'($urandom), 3'($urandom));
    end else if (r < 98) begin
      send_req(MODE_WRITE, 3'($urandom), 8'($urandom), 1'($urandom), 3'($urandom));
    end else begin
      send_req(MODE_NONE, 3'($urandom), 8'($urandom), 1'($urandom), 3'($urandom));
    end
  endtask

  // ---------------------------------------------------------------------
  // Directed tests
  // ---------------------------------------------------------------------

  // reset values through the read map, plus a no-op request
  task automatic test_register_map();
    send_req(MODE_READ, OFF_CTL_A, 8'h00, 1'b0, 3'b000);
    send_req(MODE_READ, OFF_STATUS, 8'h00, 1'b0, 3'b000);
    send_req(MODE_READ, 3'd2, 8'h00, 1'b0, 3'b000);
    send_req(MODE_READ, 3'd3, 8'h00, 1'b0, 3'b000);
    send_req(MODE_NONE, 3'd7, 8'hff, 1'b1, 3'b111);
  endtask

  // word mode: latch 1, count down through zero, irq, then the
  // status-read / counter-read pair clears the flag
  task automatic test_word_underflow();
    send_req(MODE_WRITE, OFF_CTL_B, 8'h41, 1'b0, 3'b000);  // offset 0 -> ch0, IE
    send_req(MODE_WRITE, 3'd2, 8'h00, 1'b0, 3'b000);
    send_req(MODE_WRITE, 3'd3, 8'h01, 1'b0, 3'b000);
    send_req(MODE_WRITE, OFF_CTL_A, 8'h40, 1'b0, 3'b000);  // ch0 IE, external clock
    send_req(MODE_TICK, 3'd0, 8'h00, 1'b0, 3'b001);
    send_req(MODE_TICK, 3'd0, 8'h00, 1'b0, 3'b001);
    send_req(MODE_READ, OFF_STATUS, 8'h00, 1'b0, 3'b000);
    send_req(MODE_READ, 3'd2, 8'h00, 1'b0, 3'b000);
  endtask

  // dual-byte mode on ch1 with internal clock; source change reloads
  task automatic test_dual_byte();
    send_req(MODE_WRITE, 3'd4, 8'h01, 1'b0, 3'b000);
    send_req(MODE_WRITE, 3'd5, 8'h00, 1'b0, 3'b000);
    send_req(MODE_WRITE, OFF_CTL_B, 8'h47, 1'b0, 3'b000);
    send_req(MODE_TICK, 3'd0, 8'h00, 1'b1, 3'b000);
    send_req(MODE_TICK, 3'd0, 8'h00, 1'b1, 3'b000);
  endtask

  // global hold: ticks ignored, release reloads every count; no-reload
  // latch write leaves ch0 count alone
  task automatic test_reset_hold();
    send_req(MODE_WRITE, OFF_CTL_A, 8'h53, 1'b0, 3'b000);
    send_req(MODE_TICK, 3'd0, 8'h00, 1'b1, 3'b111);
    send_req(MODE_WRITE, 3'd6, 8'hff, 1'b0, 3'b000);
    send_req(MODE_WRITE, 3'd7, 8'h00, 1'b0, 3'b000);
    send_req(MODE_WRITE, OFF_CTL_A, 8'h52, 1'b0, 3'b000);
    send_req(MODE_WRITE, 3'd2, 8'hff, 1'b0, 3'b000);
    send_req(MODE_WRITE, 3'd3, 8'hff, 1'b0, 3'b000);
    send_req(MODE_READ, 3'd6, 8'h00, 1'b0, 3'b000);
    send_req(MODE_READ, 3'd7, 8'h00, 1'b0, 3'b000);
  endtask

  // sink holds off while the source keeps offering, then the source
  // waits for every response before going on
  task automatic test_backpressure();
    rx_hold_ask++;
    repeat (60) random_op();
    drain_responses();
  endtask

  task automatic test_random();
    int stop_at;
    stop_at = req_count + RANDOM_REQS;
    while (req_count < stop_at) random_op();
  endtask

  // ---------------------------------------------------------------------
  // Sink side: ready pattern changes style at random intervals; a test
  // can request one long hold-off.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (rx_hold_seen != rx_hold_ask) begin
      rx_hold_seen  <= rx_hold_ask;
      rx_hold_left  <= RX_HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (rx_hold_left > 0) begin
      rx_hold_left  <= rx_hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      if (rx_span == 0) begin
        rx_style <= $urandom_range(0, 3);
        rx_span  <= $urandom_range(8, 80);
      end else begin
        rx_span <= rx_span - 1;
      end
      case (rx_style)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= 1'($urandom);
        2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
        default: m_axis_tready <= (rx_span % 5) != 0;
      endcase
    end
  end

  // response check, field by field against the oldest expectation
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (timer_resp_q.size() == 0) begin
        $display("%0t: response expected none, got %h", $time, m_axis_tdata);
        mismatch_count++;
      end else begin
        resp_want = timer_resp_q.pop_front();
        if (m_axis_tdata[RD_LO +: 8] !== resp_want[7:0]) begin
          $display("%0t: read_data expected %h, got %h", $time, resp_want[7:0],
                   m_axis_tdata[RD_LO +: 8]);
          mismatch_count++;
        end
        if (m_axis_tdata[IRQ_BIT] !== resp_want[8]) begin
          $display("%0t: irq expected %b, got %b", $time, resp_want[8],
                   m_axis_tdata[IRQ_BIT]);
          mismatch_count++;
        end
        if (m_axis_tdata[FIRED_LO +: 3] !== resp_want[11:9]) begin
          $display("%0t: fired expected %b, got %b", $time, resp_want[11:9],
                   m_axis_tdata[FIRED_LO +: 3]);
          mismatch_count++;
        end
        if (m_axis_tdata[M_DATA_W-1:12] !== '0) begin
          $display("%0t: pad expected 0, got %h", $time, m_axis_tdata[M_DATA_W-1:12]);
          mismatch_count++;
        end
      end
    end
  end

  // watchdog: too long without any handshake on either side
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("three_channel_programmable_timer_core: mismatch");
        $finish;
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_register_map();
    test_word_underflow();
    test_dual_byte();
    test_reset_hold();
    test_backpressure();
    test_random();
    drain_responses();
    repeat (8) @(posedge clk);  // leave a margin before the verdict
    if (mismatch_count == 0)
      $display("three_channel_programmable_timer_core: match");
    else
      $display("three_channel_programmable_timer_core: mismatch");
    $finish;
  end

endmodule
